// ===== design/fpfa_pkg.sv =====
// Shared types and constants for the fixed-partition fit allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package fpfa_pkg;

    localparam int PARTITIONS = 8;
    localparam int SIZE_BITS  = 16;
    localparam int NREGS      = 8;
    localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] POL_BEST      = 2'd0;
    localparam logic [1:0] POL_FIRST     = 2'd1;
    localparam logic [1:0] POL_WORST     = 2'd2;
    localparam logic [1:0] POL_UNDEFINED = 2'd3;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  fit_policy;
        logic [15:0] request_size;
        logic [2:0]  free_index;
        logic        batch_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  granted_index;
        logic [15:0] leftover;
        logic        batch_last;
    } out_item_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FIN
    } fsm_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] scan_idx;
        logic             finish;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_full;
    } dp_stat_t;

endpackage

// ===== design/fixed_partition_fit_allocator.sv =====
// Fixed-partition allocator with best, first and worst fit over eight partitions.
// An allocate beat scans the partitions in SCAN, one partition per cycle, then FIN loads
// its result into the output register; a free beat goes straight to FIN. A new beat is taken
// only in IDLE, after FIN; the next beat is taken while a result waits in the output register.
// Reset: asynchronous, active low; all partitions free, partition sizes zero.
// Depends on fpfa_pkg, fpfa_ctrl and fpfa_dp.
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.opcode),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    fpfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== design/fpfa_ctrl.sv =====
// Controller state machine of the fit allocator: accept, scan sequencing, result hand-off.
// Depends on fpfa_pkg.
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_op,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output logic     in_stall,
    output dp_cmd_t  cmd
);

    fsm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_free;

    assign out_free = !stat.out_full || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = (in_op == OP_FREE) ? FSM_FIN : FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (cnt_reg == IDX_W'(PARTITIONS - 1))
                begin
                    state_next = FSM_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FSM_FIN:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.scan_idx = cnt_reg;
        cmd.finish   = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            FSM_SCAN:
            begin
                cmd.step = 1'b1;
            end
            FSM_FIN:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/fpfa_dp.sv =====
// Datapath of the fit allocator: size registers, free flags, scan compare and output register.
// Depends on fpfa_pkg.
module fpfa_dp
    import fpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              in_data,
    input  logic                  out_stall,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  out_valid,
    output out_item_t             out_data
);

    logic [15:0]           size_reg [NREGS];
    logic [PARTITIONS-1:0] free_reg, free_next;
    in_item_t              item_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_BITS-1:0]  best_cap_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg, out_next;

    logic [SIZE_BITS-1:0]  req;
    logic [SIZE_BITS-1:0]  cap;
    logic                  fits;
    logic                  take;

    assign req  = SIZE_BITS'(item_reg.request_size);
    assign cap  = SIZE_BITS'(size_reg[CFG_IDX_W'(cmd.scan_idx)]);
    assign fits = free_reg[cmd.scan_idx] && (cap >= req);

    // First candidate always wins; later ones only improve best or worst fit.
    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (item_reg.fit_policy == POL_BEST)
            begin
                take = cap < best_cap_reg;
            end
            else if (item_reg.fit_policy == POL_WORST)
            begin
                take = cap > best_cap_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                size_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            size_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb
    begin
        out_next  = '0;
        free_next = free_reg;
        out_next.batch_last = item_reg.batch_end;
        if (item_reg.opcode == OP_FREE)
        begin
            out_next.status        = ST_FREED;
            out_next.granted_index = item_reg.free_index;
            if (32'(item_reg.free_index) < PARTITIONS)
            begin
                free_next[IDX_W'(item_reg.free_index)] = 1'b1;
            end
        end
        else if (found_reg && (item_reg.fit_policy != POL_UNDEFINED))
        begin
            out_next.status        = ST_ALLOCATED;
            out_next.granted_index = 3'(best_idx_reg);
            out_next.leftover      = 16'(best_cap_reg - req);
            free_next[best_idx_reg] = 1'b0;
        end
        else
        begin
            out_next.status = ST_NO_FIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= '1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.step && take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                free_reg      <= free_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.step && take)
        begin
            best_idx_reg <= cmd.scan_idx;
            best_cap_reg <= cap;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

endmodule

// ===== tb/tb_fixed_partition_fit_allocator.sv =====
// Self-checking testbench for the fixed-partition fit allocator: a directed table,
// then random phases under several partition size settings, checked by a predictor.
// Depends on fpfa_pkg and fixed_partition_fit_allocator.
module tb_fixed_partition_fit_allocator
    import fpfa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         REG_PART_SIZE_0 = 0;
    localparam int         N_PHASES        = 6;
    localparam int         BEATS_PER_PHASE = 140;
    localparam int         HOLD_PHASE      = 2;
    localparam int         PAUSE_PHASE     = 3;
    localparam int         LONG_HOLD       = 300;
    localparam int         QUIET_LIMIT     = 2000;
    localparam int         TAIL_CYCLES     = 24;

    typedef enum logic { ROW_BEAT, ROW_RESIZE } row_kind_t;

    typedef struct {
        row_kind_t kind;
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow of the allocator: partition capacities and free flags.
    logic        part_free [PARTITIONS];
    logic [15:0] part_cap  [PARTITIONS];
    logic [15:0] size_plan [PARTITIONS];

    out_item_t   pending_grants [$];
    dir_row_t    dir_rows [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          stall_left     = 0;
    int          rx_hold_req    = 0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;

    fixed_partition_fit_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic out_item_t predict_grant(in_item_t req);
        out_item_t res;
        int        pick;
        res            = '0;
        res.status     = ST_NO_FIT;
        res.batch_last = req.batch_end;
        pick           = -1;
        if (req.opcode == OP_FREE)
        begin
            part_free[req.free_index] = 1'b1;
            res.status                = ST_FREED;
            res.granted_index         = req.free_index;
        end
        else if (req.fit_policy != POL_UNDEFINED)
        begin
            for (int p = 0; p < PARTITIONS; p++)
            begin
                if (!part_free[p] || part_cap[p] < req.request_size)
                    continue;
                // First fit keeps the first candidate; the others replace it only on a
                // strict improvement, so ties stay with the lower index.
                if (pick < 0)
                    pick = p;
                else if (req.fit_policy == POL_BEST && part_cap[p] < part_cap[pick])
                    pick = p;
                else if (req.fit_policy == POL_WORST && part_cap[p] > part_cap[pick])
                    pick = p;
            end
            if (pick >= 0)
            begin
                part_free[pick]   = 1'b0;
                res.status        = ST_ALLOCATED;
                res.granted_index = 3'(pick);
                res.leftover      = part_cap[pick] - req.request_size;
            end
        end
        return res;
    endfunction

    task automatic add_beat(logic op, logic [1:0] pol, logic [15:0] sz, logic [2:0] idx,
                            logic last, bit typed, logic [1:0] st, logic [2:0] gi,
                            logic [15:0] lo);
        dir_row_t row;
        row.kind                = ROW_BEAT;
        row.req.opcode          = op;
        row.req.fit_policy      = pol;
        row.req.request_size    = sz;
        row.req.free_index      = idx;
        row.req.batch_end       = last;
        row.typed               = typed;
        row.want.status         = st;
        row.want.granted_index  = gi;
        row.want.leftover       = lo;
        row.want.batch_last     = last;
        dir_rows.push_back(row);
    endtask

    task automatic send_beat(in_item_t req, bit typed, out_item_t want);
        out_item_t predicted;
        int        gap;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = predict_grant(req);
        pending_grants.push_back(typed ? want : predicted);
    endtask

    task automatic finish_pending();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    // Only called with nothing in flight, so the shadow can follow at once.
    task automatic write_sizes();
        for (int p = 0; p < PARTITIONS; p++)
        begin
            @(negedge clk);
            cfg_we      <= 1'b1;
            cfg_index   <= CFG_IDX_W'(REG_PART_SIZE_0 + p);
            cfg_wdata   <= size_plan[p];
            part_cap[p]  = size_plan[p];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic compare_field(string what, logic [15:0] exp_val, logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %p", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = pending_grants.pop_front();
                compare_field("status", 16'(want.status), 16'(out_data.status));
                compare_field("granted_index", 16'(want.granted_index),
                              16'(out_data.granted_index));
                compare_field("leftover", want.leftover, out_data.leftover);
                compare_field("batch_last", 16'(want.batch_last), 16'(out_data.batch_last));
            end
        end
    end

    // Result side back-pressure: short random bursts, or one long hold on request.
    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            stall_left  = rx_hold_req;
            rx_hold_req = 0;
        end
        else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_fixed_partition_fit_allocator: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_item_t req;
        int       pick;
        for (int p = 0; p < PARTITIONS; p++)
        begin
            part_free[p] = 1'b1;
            part_cap[p]  = '0;
        end

        // After reset every capacity is zero: only a zero request can be placed.
        add_beat(OP_ALLOC, POL_BEST, 16'd0, 3'd7, 1'b1, 1'b1, ST_ALLOCATED, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_FIRST, 16'd1, 3'd0, 1'b0, 1'b1, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_UNDEFINED, 16'd0, 3'd0, 1'b1, 1'b1, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_FREE, POL_BEST, 16'd0, 3'd0, 1'b0, 1'b1, ST_FREED, 3'd0, 16'd0);
        add_beat(OP_FREE, POL_WORST, 16'd9, 3'd5, 1'b1, 1'b1, ST_FREED, 3'd5, 16'd0);
        dir_rows.push_back('{ROW_RESIZE, '0, 1'b0, '0});
        add_beat(OP_ALLOC, POL_BEST, 16'd50, 3'd0, 1'b0, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_BEST, 16'd50, 3'd0, 1'b1, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_WORST, 16'd100, 3'd0, 1'b0, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_FIRST, 16'd101, 3'd0, 1'b0, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_WORST, 16'd0, 3'd0, 1'b1, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_FIRST, 16'hFFFF, 3'd0, 1'b0, 1'b1, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_FREE, POL_BEST, 16'd0, 3'd4, 1'b0, 1'b1, ST_FREED, 3'd4, 16'd0);
        add_beat(OP_ALLOC, POL_FIRST, 16'hFFFF, 3'd7, 1'b1, 1'b1, ST_ALLOCATED, 3'd4, 16'd0);
        add_beat(OP_ALLOC, POL_BEST, 16'd0, 3'd0, 1'b0, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_UNDEFINED, 16'hFFFF, 3'd7, 1'b1, 1'b1, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_FREE, POL_UNDEFINED, 16'hFFFF, 3'd7, 1'b1, 1'b1, ST_FREED, 3'd7, 16'd0);
        add_beat(OP_FREE, POL_FIRST, 16'h5A5A, 3'd7, 1'b0, 1'b1, ST_FREED, 3'd7, 16'd0);
        add_beat(OP_ALLOC, POL_WORST, 16'd120, 3'd0, 1'b0, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_FIRST, 16'd0, 3'd0, 1'b1, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_ALLOC, POL_BEST, 16'd1, 3'd0, 1'b0, 1'b0, ST_NO_FIT, 3'd0, 16'd0);
        add_beat(OP_FREE, POL_BEST, 16'd0, 3'd2, 1'b0, 1'b1, ST_FREED, 3'd2, 16'd0);
        add_beat(OP_FREE, POL_BEST, 16'd0, 3'd6, 1'b1, 1'b1, ST_FREED, 3'd6, 16'd0);
        add_beat(OP_ALLOC, POL_BEST, 16'd150, 3'd0, 1'b1, 1'b0, ST_NO_FIT, 3'd0, 16'd0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].kind == ROW_RESIZE)
            begin
                finish_pending();
                size_plan = '{16'd100, 16'd50, 16'd200, 16'd50,
                              16'hFFFF, 16'd0, 16'd300, 16'd120};
                write_sizes();
            end
            else
                send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            finish_pending();
            for (int p = 0; p < PARTITIONS; p++)
            begin
                case (ph)
                    0:       size_plan[p] = 16'hFFFF;
                    1:       size_plan[p] = 16'd0;
                    2:       size_plan[p] = 16'($urandom);
                    4:
                        case ($urandom_range(0, 3))
                            0:       size_plan[p] = 16'd0;
                            1:       size_plan[p] = 16'hFFFF;
                            2:       size_plan[p] = 16'($urandom);
                            default: size_plan[p] = 16'($urandom_range(0, 15));
                        endcase
                    default: size_plan[p] = 16'($urandom_range(0, 15));
                endcase
            end
            write_sizes();
            tx_idle_en = (ph != 2) && (ph != N_PHASES - 1);
            rx_idle_en = (ph != 1) && (ph != N_PHASES - 1);

            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // The sender keeps offering beats through the hold so the block backs up.
                if (ph == HOLD_PHASE && n == 10)
                    rx_hold_req = LONG_HOLD;
                if (ph == PAUSE_PHASE && n == BEATS_PER_PHASE / 2)
                    finish_pending();

                req.opcode       = ($urandom_range(0, 99) < 35) ? OP_FREE : OP_ALLOC;
                req.fit_policy   = ($urandom_range(0, 19) == 0) ? POL_UNDEFINED
                                                                : 2'($urandom_range(0, 2));
                req.batch_end    = 1'($urandom_range(0, 1));
                pick             = $urandom_range(0, PARTITIONS - 1);
                // Mostly release a busy partition so allocations keep finding room.
                if ($urandom_range(0, 3) != 0)
                begin
                    for (int k = 0; k < PARTITIONS; k++)
                    begin
                        if (!part_free[(pick + k) % PARTITIONS])
                        begin
                            pick = (pick + k) % PARTITIONS;
                            break;
                        end
                    end
                end
                req.free_index   = 3'(pick);
                pick             = $urandom_range(0, PARTITIONS - 1);
                case ($urandom_range(0, 5))
                    0:       req.request_size = 16'd0;
                    1:       req.request_size = 16'($urandom);
                    2:       req.request_size = part_cap[pick];
                    3:       req.request_size = part_cap[pick] + 16'd1;
                    4:       req.request_size = (part_cap[pick] > 16'd3)
                                 ? part_cap[pick] - 16'($urandom_range(0, 3))
                                 : part_cap[pick];
                    default: req.request_size = 16'($urandom_range(0, 15));
                endcase
                send_beat(req, 1'b0, '0);
            end
        end

        finish_pending();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_fixed_partition_fit_allocator: clean");
        else
            $display("tb_fixed_partition_fit_allocator: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fpfa_pkg.sv
design/fpfa_ctrl.sv
design/fpfa_dp.sv
design/fixed_partition_fit_allocator.sv
tb/tb_fixed_partition_fit_allocator.sv
